// ===== src/uuid_v5_sha1_generator_top_assert.svh =====
// Assertion macros for the UUID v5 generator checker.
`ifndef UUID_V5_SHA1_GENERATOR_TOP_ASSERT_SVH
`define UUID_V5_SHA1_GENERATOR_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define UV5_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uuid v5 check failed");
// Next-cycle implication checked outside reset.
`define UV5_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uuid v5 check failed");
`endif

// ===== src/uv5_pkg.sv =====
// ----------------------------------------------------------------------------
// UUID v5 package
// Shared constants and SHA-1 round helpers.
// ----------------------------------------------------------------------------
package uv5_pkg;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic CfgNsHigh = 1'b0;
  localparam logic CfgNsLow  = 1'b1;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] f_fn(input logic [6:0] r, input logic [31:0] b,
                                       input logic [31:0] c, input logic [31:0] d);
    if (r < 7'd20) begin
      f_fn = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f_fn = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f_fn = (b & c) | (b & d) | (c & d);
    end else begin
      f_fn = b ^ c ^ d;
    end
  endfunction

  function automatic logic [31:0] k_fn(input logic [6:0] r);
    if (r < 7'd20) begin
      k_fn = K0;
    end else if (r < 7'd40) begin
      k_fn = K1;
    end else if (r < 7'd60) begin
      k_fn = K2;
    end else begin
      k_fn = K3;
    end
  endfunction
endpackage

// ===== src/uv5_core.sv =====
// ----------------------------------------------------------------------------
// UUID v5 SHA-1 compression core
// Runs 80 rounds over the 16-word schedule memory, one round per cycle.
// ----------------------------------------------------------------------------
module uv5_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         init_i,
  input  logic         wr_en_i,
  input  logic [3:0]   wr_addr_i,
  input  logic [31:0]  wr_data_i,
  output logic         done_o,
  output logic [159:0] chain_o
);
  import uv5_pkg::*;

  logic [31:0] w_mem [16];
  logic [31:0] rd_q;
  logic [3:0]  rd_addr;
  logic [6:0]  rnd_q, rnd_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] h_q [5];
  logic [31:0] wi, t;

  // Round r needs w[r]. The first 16 words come from the memory; later words
  // are computed from a shift window of the last 16 words kept in flip-flops.
  logic [31:0] win_q [16];

  assign rd_addr = busy_q ? (rnd_q[3:0] + 4'd1) : 4'd0;

  always_comb begin
    wi = (rnd_q < 7'd16) ? rd_q
       : rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);
    t = rotl(a_q, 5) + f_fn(rnd_q, b_q, c_q, d_q) + e_q + k_fn(rnd_q) + wi;
    rnd_d = rnd_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      rnd_d = '0;
    end else if (busy_q) begin
      if (rnd_q == 7'd79) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      rnd_d = rnd_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !busy_q) begin
      w_mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= w_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
    end else if (busy_q) begin
      e_q <= d_q; d_q <= c_q; c_q <= rotl(b_q, 30); b_q <= a_q; a_q <= t;
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= wi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
    end else begin
      rnd_q <= rnd_d;
      busy_q <= busy_d;
      done_q <= done_d;
      if (init_i) begin
        h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
      end else if (done_d) begin
        h_q[0] <= h_q[0] + t;
        h_q[1] <= h_q[1] + a_q;
        h_q[2] <= h_q[2] + rotl(b_q, 30);
        h_q[3] <= h_q[3] + c_q;
        h_q[4] <= h_q[4] + d_q;
      end
    end
  end

  assign done_o = done_q;
  assign chain_o = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
endmodule

// ===== src/uuid_v5_sha1_generator_top.sv =====
// ----------------------------------------------------------------------------
// UUID v5 generator top level
// Streams namespace and name bytes into SHA-1 and emits a version 5 UUID.
// ----------------------------------------------------------------------------
// Usage: write namespace_high (index 0) and namespace_low (index 1) on the
// configuration channel; cfg_ready_o is high only while the block is idle.
// Name bytes arrive one item per handshake on the input channel (valid_i,
// stall_o); an item with last_i closes the name, and byte_present_i low
// carries no byte. An item is taken in an idle cycle, then stall_o is high
// for one cycle while its byte is written, so the block takes no new item
// before that byte is written. The first item of a message first writes the
// 16 namespace bytes. A byte that fills a 64-byte block launches the core,
// which runs 80 rounds and then folds the result into the chain value. A
// closing item writes padding one byte per cycle up to byte 55, two length
// words, and runs the compression (twice when the padding spills into a new
// block), after which the UUID is held on out_valid_o until out_stall_i is
// low, and no new item is taken meanwhile. Reset restores the SHA-1 initial
// values, clears the namespace and leaves no message open.
module uuid_v5_sha1_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  name_byte_i,
  input  logic        byte_present_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] uuid_high_o,
  output logic [63:0] uuid_low_o
);
  import uv5_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StNs   = 3'd1;
  localparam logic [2:0] StByte = 3'd2;
  localparam logic [2:0] StPad  = 3'd3;
  localparam logic [2:0] StLen  = 3'd4;
  localparam logic [2:0] StComp = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]   st_q, ret_q;
  logic [63:0]  nsh_q, nsl_q;
  logic [63:0]  cnt_q;
  logic         open_q, lastp_q, bytep_q, first_q, lenw_q, go_q;
  logic [7:0]   byte_q;
  logic [3:0]   nsi_q;
  logic [5:0]   ppos_q;
  logic [31:0]  word_q;
  logic         wr_en, start, init, core_done;
  logic [3:0]   wr_addr;
  logic [31:0]  wr_data, wr_word;
  logic [5:0]   pos;
  logic [63:0]  ns_sel;
  logic [2:0]   ns_sh;
  logic [7:0]   cur_byte;
  logic [159:0] chain;
  logic [63:0]  hi, lo;

  assign cfg_ready_o = (st_q == StIdle);
  assign stall_o = (st_q != StIdle);
  assign init = (st_q == StIdle) && valid_i && !open_q;
  assign start = (st_q == StComp) && !go_q;

  uv5_core u_core (
    .clk_i, .rst_ni, .start_i(start), .init_i(init), .wr_en_i(wr_en),
    .wr_addr_i(wr_addr), .wr_data_i(wr_data), .done_o(core_done), .chain_o(chain)
  );

  always_comb begin
    ns_sel = nsi_q[3] ? nsl_q : nsh_q;
    ns_sh = 3'd7 - nsi_q[2:0];
    pos = (st_q == StPad) ? ppos_q : cnt_q[8:3];
    cur_byte = byte_q;
    if (st_q == StNs) begin
      cur_byte = ns_sel[{ns_sh, 3'b000} +: 8];
    end else if (st_q == StPad) begin
      cur_byte = first_q ? 8'h80 : 8'h00;
    end
    case (pos[1:0])
      2'd0: wr_word = {cur_byte, 24'd0};
      2'd1: wr_word = {word_q[31:24], cur_byte, 16'd0};
      2'd2: wr_word = {word_q[31:16], cur_byte, 8'd0};
      default: wr_word = {word_q[31:8], cur_byte};
    endcase
    wr_en = (st_q == StNs) || (st_q == StPad) || (st_q == StLen)
         || ((st_q == StByte) && bytep_q);
    wr_addr = pos[5:2];
    wr_data = wr_word;
    if (st_q == StLen) begin
      wr_addr = lenw_q ? 4'd15 : 4'd14;
      wr_data = lenw_q ? cnt_q[31:0] : cnt_q[63:32];
    end
    hi = {chain[159:112], 4'h5, chain[107:96]};
    lo = {2'b10, chain[93:32]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ret_q <= StIdle;
      nsh_q <= '0;
      nsl_q <= '0;
      cnt_q <= '0;
      open_q <= 1'b0;
      lastp_q <= 1'b0;
      bytep_q <= 1'b0;
      first_q <= 1'b0;
      lenw_q <= 1'b0;
      go_q <= 1'b0;
      byte_q <= '0;
      nsi_q <= '0;
      ppos_q <= '0;
      word_q <= '0;
      out_valid_o <= 1'b0;
      uuid_high_o <= '0;
      uuid_low_o <= '0;
    end else begin
      go_q <= (st_q == StComp);
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgNsHigh: nsh_q <= cfg_data_i;
          CfgNsLow:  nsl_q <= cfg_data_i;
        endcase
      end
      if (wr_en) word_q <= wr_data;
      unique case (st_q)
        StIdle: begin
          if (valid_i) begin
            byte_q <= name_byte_i;
            bytep_q <= byte_present_i;
            lastp_q <= last_i;
            if (!open_q) begin
              cnt_q <= '0;
              nsi_q <= '0;
              st_q <= StNs;
              open_q <= 1'b1;
            end else begin
              st_q <= StByte;
            end
          end
        end
        StNs: begin
          cnt_q <= cnt_q + 64'd8;
          nsi_q <= nsi_q + 4'd1;
          if (nsi_q == 4'd15) st_q <= StByte;
        end
        StByte: begin
          ppos_q <= bytep_q ? pos + 6'd1 : pos;
          first_q <= 1'b1;
          if (bytep_q) cnt_q <= cnt_q + 64'd8;
          if (bytep_q && pos == 6'd63) begin
            st_q <= StComp;
            ret_q <= lastp_q ? StPad : StIdle;
          end else if (lastp_q) begin
            st_q <= StPad;
          end else begin
            st_q <= StIdle;
          end
        end
        StPad: begin
          first_q <= 1'b0;
          ppos_q <= ppos_q + 6'd1;
          if (ppos_q == 6'd63) begin
            st_q <= StComp;
            ret_q <= StPad;
          end else if (ppos_q == 6'd55) begin
            st_q <= StLen;
            lenw_q <= 1'b0;
          end
        end
        StLen: begin
          lenw_q <= 1'b1;
          if (lenw_q) begin
            st_q <= StComp;
            ret_q <= StOut;
          end
        end
        StComp: begin
          if (core_done) begin
            st_q <= ret_q;
            if (ret_q == StOut) begin
              out_valid_o <= 1'b1;
              uuid_high_o <= hi;
              uuid_low_o <= lo;
            end
          end
        end
        StOut: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            open_q <= 1'b0;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== src/uuid_v5_sha1_generator_checker.sv =====
// ----------------------------------------------------------------------------
// UUID v5 generator checker
// Port-level properties of the generator, attached by bind.
// ----------------------------------------------------------------------------
`include "uuid_v5_sha1_generator_top_assert.svh"
module uuid_v5_sha1_generator_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] uuid_high_o,
  input logic [63:0] uuid_low_o
);
  `UV5_ASSERT_IMP(a_version, clk_i, rst_ni, out_valid_o, uuid_high_o[15:12] == 4'h5)
  `UV5_ASSERT_IMP(a_variant, clk_i, rst_ni, out_valid_o, uuid_low_o[63:62] == 2'b10)
  `UV5_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o && $stable(uuid_high_o))
  `UV5_ASSERT_IMP(a_busy, clk_i, rst_ni, out_valid_o, stall_o)
endmodule

bind uuid_v5_sha1_generator_top uuid_v5_sha1_generator_checker u_chk (.*);

// ===== tb/uv5_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID v5 result checker
// Watches the configuration, name and result channels of the UUID v5
// generator. It keeps its own SHA-1 state to predict every UUID, and it
// compares each result against the oldest prediction, counting mismatches.
// ----------------------------------------------------------------------------
module uv5_checker
  import uv5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        valid_i,
  input  logic        stall_i,
  input  logic [7:0]  name_byte_i,
  input  logic        byte_present_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] uuid_high_i,
  input  logic [63:0] uuid_low_i,
  output int          err_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } uuid_t;

  uuid_t       uuid_q[$];
  logic [63:0] ns_high;
  logic [63:0] ns_low;
  logic [31:0] blk_words[16];
  logic [31:0] hash_words[5];
  logic [63:0] msg_bits;
  logic        msg_open;

  assign pending_o = uuid_q.size();

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    rol32 = (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_block();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk_words[i];
    for (int i = 16; i < 80; i++) w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = hash_words[0]; b = hash_words[1]; c = hash_words[2];
    d = hash_words[3]; e = hash_words[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rol32(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol32(b, 30); b = a; a = t;
    end
    hash_words[0] += a; hash_words[1] += b; hash_words[2] += c;
    hash_words[3] += d; hash_words[4] += e;
  endfunction

  function automatic void place_byte(input logic [5:0] pos, input logic [7:0] v);
    int sh;
    sh = (3 - pos[1:0]) * 8;
    if (pos[1:0] == 2'd0) blk_words[pos[5:2]] = 32'(v) << sh;
    else blk_words[pos[5:2]] |= 32'(v) << sh;
    if (pos == 6'd63) sha1_block();
  endfunction

  function automatic void take_byte(input logic [7:0] v);
    place_byte(msg_bits[8:3], v);
    msg_bits += 64'd8;
  endfunction

  function automatic void start_message();
    hash_words = '{H0, H1, H2, H3, H4};
    msg_bits = '0;
    for (int i = 7; i >= 0; i--) take_byte(ns_high[8*i +: 8]);
    for (int i = 7; i >= 0; i--) take_byte(ns_low[8*i +: 8]);
    msg_open = 1'b1;
  endfunction

  function automatic uuid_t close_message();
    logic [5:0] pos;
    uuid_t u;
    pos = msg_bits[8:3];
    place_byte(pos, 8'h80);
    pos++;
    while (pos != 6'd56) begin
      place_byte(pos, 8'h00);
      pos++;
    end
    blk_words[14] = msg_bits[63:32];
    blk_words[15] = msg_bits[31:0];
    sha1_block();
    u.high = {hash_words[0], hash_words[1]};
    u.low  = {hash_words[2], hash_words[3]};
    u.high[15:12] = 4'h5;
    u.low[63:62]  = 2'b10;
    msg_open = 1'b0;
    return u;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    uuid_t exp_u;
    uuid_t new_u;
    if (!rst_ni) begin
      ns_high    = '0;
      ns_low     = '0;
      msg_bits   = '0;
      msg_open   = 1'b0;
      hash_words = '{H0, H1, H2, H3, H4};
      for (int i = 0; i < 16; i++) blk_words[i] = '0;
      err_cnt_o  = 0;
      uuid_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (uuid_q.size() == 0) begin
          $display("%0t: unexpected UUID %h %h", $time, uuid_high_i, uuid_low_i);
          err_cnt_o++;
        end else begin
          exp_u = uuid_q.pop_front();
          if (uuid_high_i !== exp_u.high) begin
            $display("%0t: uuid_high expected %h actual %h", $time, exp_u.high, uuid_high_i);
            err_cnt_o++;
          end
          if (uuid_low_i !== exp_u.low) begin
            $display("%0t: uuid_low expected %h actual %h", $time, exp_u.low, uuid_low_i);
            err_cnt_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgNsHigh) ns_high = cfg_data_i;
        else ns_low = cfg_data_i;
      end
      if (valid_i && !stall_i) begin
        if (!msg_open) start_message();
        if (byte_present_i) take_byte(name_byte_i);
        if (last_i) begin
          new_u = close_message();
          uuid_q = {uuid_q, new_u};
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID v5 generator testbench
// Drives namespaces and streamed names of many lengths into the generator,
// including empty names, block and padding boundaries, and byteless items,
// under several idle and stall patterns; a checker predicts every UUID.
// ----------------------------------------------------------------------------
module tb_top;
  import uv5_pkg::*;

  localparam int StallLimit = 5000;
  localparam int ItemTarget = 950;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = CfgNsHigh;
  logic [63:0] cfg_data_i = '0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [7:0]  name_byte_i = '0;
  logic        byte_present_i = 1'b0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] uuid_high_o;
  logic [63:0] uuid_low_o;
  int          err_cnt;
  int          pending;
  int          idle_mode = 0;
  int          quiet_cycles = 0;
  int          items_sent = 0;
  int          names_sent = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  uuid_v5_sha1_generator_top dut (.*);

  uv5_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .valid_i, .stall_i(stall_o), .name_byte_i, .byte_present_i, .last_i,
    .out_valid_i(out_valid_o), .out_stall_i, .uuid_high_i(uuid_high_o),
    .uuid_low_i(uuid_low_o), .err_cnt_o(err_cnt), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_stall_i <= (idle_mode >= 2)
                 ? ($urandom_range(0, 99) < ((idle_mode == 3) ? 25 : 47)) : 1'b0;
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (cfg_valid_i && cfg_ready_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic send_item(input logic [7:0] b, input logic present, input logic close);
    int gap;
    int pct;
    gap = 0;
    pct = (idle_mode == 3) ? 25 : ((idle_mode == 1) ? 47 : 0);
    if (pct > 0 && $urandom_range(0, 99) < pct) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i        <= 1'b1;
    name_byte_i    <= b;
    byte_present_i <= present;
    last_i         <= close;
    do @(posedge clk_i); while (stall_o);
    items_sent++;
    if (close) names_sent++;
  endtask

  task automatic send_name(input int len, input bit close_empty);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !close_empty && i == len - 1);
    end
    if (close_empty || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic settle();
    valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    int boundary[9] = '{38, 39, 40, 41, 47, 48, 49, 103, 104};
    int len, r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = ph;
      case (ph)
        0: begin
          write_reg(CfgNsHigh, 64'h0); write_reg(CfgNsLow, 64'h0);
        end
        1: begin
          write_reg(CfgNsHigh, '1); write_reg(CfgNsLow, '1);
        end
        2: begin
          write_reg(CfgNsHigh, 64'h0); write_reg(CfgNsLow, '1);
        end
        default: begin
          write_reg(CfgNsHigh, {$urandom, $urandom}); write_reg(CfgNsLow, {$urandom, $urandom});
        end
      endcase
      cfg_valid_i <= 1'b0;
      if (ph == 0) begin
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
      end
      while (items_sent < ItemTarget * (ph + 1) / 4) begin
        r = $urandom_range(0, 9);
        if (r < 5) len = $urandom_range(0, 12);
        else if (r < 8) len = boundary[$urandom_range(0, 8)];
        else len = $urandom_range(13, 130);
        send_name(len, $urandom_range(0, 2) == 0);
      end
      settle();
    end

    $display("Sent %0d items forming %0d names over four namespaces,", items_sent, names_sent);
    $display("with idle and stall patterns on both channels.");
    if (err_cnt == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
